// ----- rtl/core/huffman_code_builder_macros.svh -----
// Assertion macros shared by the checker.
`ifndef HUFFMAN_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_MACROS_SVH

// Implication checked on the same edge.
`define HCB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcb check failed");

// Implication checked on the following edge.
`define HCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcb check failed");

`endif

// ----- rtl/core/hcb_pkg.sv -----
`default_nettype none

package hcb_pkg;

    localparam int SYMBOL_W = 6;
    localparam int CODE_W   = 63;
    localparam int LENGTH_W = 6;
    localparam int COUNT_W  = 7;
    localparam int INPUT_W  = 16;
    localparam int PADDR_W  = 3;

    localparam logic [PADDR_W-1:0] ADDR_SYMBOL_COUNT = 3'd0;
    localparam logic [COUNT_W-1:0] COUNT_RESET       = 7'd64;
    localparam logic [LENGTH_W-1:0] LENGTH_MAX       = 6'd63;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PREP,
        ST_INIT,
        ST_SCAN,
        ST_LINK1,
        ST_LINK2,
        ST_WSTART,
        ST_WP,
        ST_WL,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/huffman_code_builder.sv -----
// huffman_code_builder: Huffman code construction over a block of weights.
// Input channel (in_valid / in_stall / weight): one weight per beat, in
// symbol order. After symbol_count beats the block builds the tree and
// then drives one output beat per symbol (symbol, code_bits, code_length,
// last_code), symbol 0 first, last_code high on the final one.
// While building and emitting, in_stall is high; weights load at one per
// cycle otherwise.
// The tree build follows the final weight: a prep step, an init pass over
// the node memories, then for each internal node i (i = n+1 .. 2n-1) a
// rescan of node memory one slot per cycle and two link steps.
// Each code is then built by walking the tree one level at a time through
// the parent memory port.
// An output beat holds in the output registers while out_stall is high;
// the walk resumes only once the beat is taken.
// Reset clears the load count, sets symbol_count to 64 and returns to
// the load state; node memories are not cleared and need not be.
// symbol_count is written over the APB port at address 0; the user must
// write it only while idle, which the block itself does not enforce;
// 0 acts as 1 and values above MAX_SYMBOLS act as MAX_SYMBOLS.
`default_nettype none

module huffman_code_builder #(
    parameter int MAX_SYMBOLS = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [hcb_pkg::PADDR_W-1:0]      paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [hcb_pkg::INPUT_W-1:0]      weight,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [hcb_pkg::SYMBOL_W-1:0]     symbol,
    output logic [hcb_pkg::CODE_W-1:0]       code_bits,
    output logic [hcb_pkg::LENGTH_W-1:0]     code_length,
    output logic                             last_code
);

    localparam int NODE_AW = $clog2(2 * MAX_SYMBOLS);
    localparam int LEAF_AW = $clog2(MAX_SYMBOLS);
    localparam int NODE_WB = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
    localparam int NODES   = 2 ** NODE_AW;
    localparam int LEAVES  = 2 ** LEAF_AW;

    // memories
    logic [WEIGHT_BITS-1:0] leaf_mem [LEAVES];
    logic [NODE_WB-1:0]     wgt_mem  [NODES];
    logic [NODE_AW-1:0]     par_mem  [NODES];
    logic [NODE_AW-1:0]     left_mem [LEAVES];

    logic                   lf_we, wg_we, pa_we, lc_we;
    logic [LEAF_AW-1:0]     lf_waddr, lf_raddr, lc_waddr, lc_raddr;
    logic [NODE_AW-1:0]     wg_waddr, wg_raddr, pa_waddr, pa_raddr;
    logic [WEIGHT_BITS-1:0] lf_wdata, lf_rdata;
    logic [NODE_WB-1:0]     wg_wdata, wg_rdata;
    logic [NODE_AW-1:0]     pa_wdata, pa_rdata, lc_wdata, lc_rdata;

    always_ff @(posedge clk)
    begin
        if (lf_we) leaf_mem[lf_waddr] <= lf_wdata;
        lf_rdata <= leaf_mem[lf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wg_we) wgt_mem[wg_waddr] <= wg_wdata;
        wg_rdata <= wgt_mem[wg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pa_we) par_mem[pa_waddr] <= pa_wdata;
        pa_rdata <= par_mem[pa_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lc_we) left_mem[lc_waddr] <= lc_wdata;
        lc_rdata <= left_mem[lc_raddr];
    end

    // control and datapath registers
    hcb_pkg::state_t                 state_reg, state_next;
    logic [hcb_pkg::COUNT_W-1:0]     count_reg;
    logic [NODE_AW-1:0]              loaded_reg, loaded_next;
    logic [NODE_AW-1:0]              j_reg, j_next;
    logic [NODE_AW-1:0]              i_reg, i_next;
    logic [NODE_AW-1:0]              k_reg, k_next;
    logic [NODE_AW-1:0]              chk_k_reg, chk_k_next;
    logic                            chk_valid_reg, chk_valid_next;
    logic                            issue_done_reg, issue_done_next;
    logic [NODE_AW-1:0]              a_reg, a_next, b_reg, b_next;
    logic [NODE_WB-1:0]              wa_reg, wa_next, wb_reg, wb_next;
    logic [LEAF_AW-1:0]              s_reg, s_next;
    logic [NODE_AW-1:0]              pos_reg, pos_next, par_reg, par_next;
    logic [hcb_pkg::CODE_W-1:0]      code_reg, code_next;
    logic [hcb_pkg::LENGTH_W-1:0]    len_reg, len_next;
    logic [hcb_pkg::SYMBOL_W-1:0]    sym_out_reg, sym_out_next;
    logic [hcb_pkg::CODE_W-1:0]      code_out_reg, code_out_next;
    logic [hcb_pkg::LENGTH_W-1:0]    len_out_reg, len_out_next;
    logic                            last_out_reg, last_out_next;

    logic                            cfg_write;
    logic [NODE_AW-1:0]              n_eff, m_last;
    logic                            in_take;
    logic                            walk_bit;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == hcb_pkg::ADDR_SYMBOL_COUNT);
    assign prdata    = (paddr == hcb_pkg::ADDR_SYMBOL_COUNT) ? 32'(count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) count_reg <= hcb_pkg::COUNT_RESET;
        else if (cfg_write) count_reg <= pwdata[hcb_pkg::COUNT_W-1:0];
    end

    // clamp the count into 1 .. MAX_SYMBOLS
    always_comb
    begin
        if (count_reg == '0)
            n_eff = NODE_AW'(1);
        else if (count_reg > hcb_pkg::COUNT_W'(MAX_SYMBOLS))
            n_eff = NODE_AW'(MAX_SYMBOLS);
        else
            n_eff = NODE_AW'(count_reg);
    end
    assign m_last = NODE_AW'({n_eff, 1'b0} - 1'b1);

    assign in_stall  = (state_reg != hcb_pkg::ST_LOAD);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = (state_reg == hcb_pkg::ST_EMIT);
    assign symbol      = sym_out_reg;
    assign code_bits   = code_out_reg;
    assign code_length = len_out_reg;
    assign last_code   = last_out_reg;
    assign walk_bit    = (lc_rdata != pos_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hcb_pkg::ST_LOAD:
                if (in_take && ({1'b0, loaded_reg} + 1'b1 >= {1'b0, n_eff}))
                    state_next = hcb_pkg::ST_PREP;
            hcb_pkg::ST_PREP:
                state_next = hcb_pkg::ST_INIT;
            hcb_pkg::ST_INIT:
                if (j_reg == m_last)
                    state_next = (n_eff == NODE_AW'(1)) ? hcb_pkg::ST_WSTART
                                                        : hcb_pkg::ST_SCAN;
            hcb_pkg::ST_SCAN:
                if (issue_done_reg && !chk_valid_reg)
                    state_next = hcb_pkg::ST_LINK1;
            hcb_pkg::ST_LINK1:
                state_next = hcb_pkg::ST_LINK2;
            hcb_pkg::ST_LINK2:
                state_next = (i_reg == m_last) ? hcb_pkg::ST_WSTART : hcb_pkg::ST_SCAN;
            hcb_pkg::ST_WSTART:
                state_next = hcb_pkg::ST_WP;
            hcb_pkg::ST_WP:
                if (pa_rdata == '0 || len_reg == hcb_pkg::LENGTH_MAX)
                    state_next = hcb_pkg::ST_EMIT;
                else
                    state_next = hcb_pkg::ST_WL;
            hcb_pkg::ST_WL:
                state_next = hcb_pkg::ST_WP;
            hcb_pkg::ST_EMIT:
                if (!out_stall)
                    state_next = last_out_reg ? hcb_pkg::ST_LOAD : hcb_pkg::ST_WSTART;
            default:
                state_next = hcb_pkg::ST_LOAD;
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        loaded_next     = loaded_reg;
        j_next          = j_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        chk_k_next      = chk_k_reg;
        chk_valid_next  = 1'b0;
        issue_done_next = issue_done_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        wa_next         = wa_reg;
        wb_next         = wb_reg;
        s_next          = s_reg;
        pos_next        = pos_reg;
        par_next        = par_reg;
        code_next       = code_reg;
        len_next        = len_reg;
        sym_out_next    = sym_out_reg;
        code_out_next   = code_out_reg;
        len_out_next    = len_out_reg;
        last_out_next   = last_out_reg;

        lf_we    = 1'b0;
        lf_waddr = LEAF_AW'(loaded_reg);
        lf_wdata = WEIGHT_BITS'(weight);
        lf_raddr = LEAF_AW'(j_reg);
        wg_we    = 1'b0;
        wg_waddr = j_reg;
        wg_wdata = NODE_WB'(lf_rdata);
        wg_raddr = k_reg;
        pa_we    = 1'b0;
        pa_waddr = j_reg;
        pa_wdata = '0;
        pa_raddr = k_reg;
        lc_we    = 1'b0;
        lc_waddr = LEAF_AW'(i_reg - n_eff - 1'b1);
        lc_wdata = a_reg;
        lc_raddr = LEAF_AW'(pa_rdata - n_eff - 1'b1);

        case (state_reg)
            hcb_pkg::ST_LOAD:
            begin
                if (in_take)
                begin
                    lf_we = ({1'b0, loaded_reg} < (NODE_AW + 1)'(MAX_SYMBOLS));
                    if ({1'b0, loaded_reg} + 1'b1 >= {1'b0, n_eff})
                        loaded_next = '0;
                    else
                        loaded_next = loaded_reg + 1'b1;
                end
                j_next = '0;
            end
            hcb_pkg::ST_PREP:
            begin
                lf_raddr = '0;
                j_next   = NODE_AW'(1);
            end
            hcb_pkg::ST_INIT:
            begin
                // lf_rdata holds leaf j-1
                pa_we    = 1'b1;
                wg_we    = (j_reg <= n_eff);
                lf_raddr = LEAF_AW'(j_reg);
                j_next   = j_reg + 1'b1;
                i_next   = n_eff + 1'b1;
                k_next          = NODE_AW'(1);
                issue_done_next = 1'b0;
                a_next          = '0;
                b_next          = '0;
                s_next          = '0;
            end
            hcb_pkg::ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_k_next     = k_reg;
                    k_next         = k_reg + 1'b1;
                    if (k_reg == i_reg - 1'b1) issue_done_next = 1'b1;
                end
                if (chk_valid_reg && pa_rdata == '0)
                begin
                    if (a_reg == '0)
                    begin
                        a_next  = chk_k_reg;
                        wa_next = wg_rdata;
                    end
                    else if (b_reg == '0)
                    begin
                        if (wa_reg > wg_rdata)
                        begin
                            b_next  = a_reg;
                            wb_next = wa_reg;
                            a_next  = chk_k_reg;
                            wa_next = wg_rdata;
                        end
                        else
                        begin
                            b_next  = chk_k_reg;
                            wb_next = wg_rdata;
                        end
                    end
                    else if (wg_rdata < wa_reg)
                    begin
                        b_next  = a_reg;
                        wb_next = wa_reg;
                        a_next  = chk_k_reg;
                        wa_next = wg_rdata;
                    end
                    else if (wg_rdata < wb_reg)
                    begin
                        b_next  = chk_k_reg;
                        wb_next = wg_rdata;
                    end
                end
            end
            hcb_pkg::ST_LINK1:
            begin
                pa_we    = 1'b1;
                pa_waddr = a_reg;
                pa_wdata = i_reg;
                lc_we    = 1'b1;
                wg_we    = 1'b1;
                wg_waddr = i_reg;
                wg_wdata = wa_reg + wb_reg;
            end
            hcb_pkg::ST_LINK2:
            begin
                pa_we    = 1'b1;
                pa_waddr = b_reg;
                pa_wdata = i_reg;
                i_next          = i_reg + 1'b1;
                k_next          = NODE_AW'(1);
                issue_done_next = 1'b0;
                a_next          = '0;
                b_next          = '0;
                s_next          = '0;
            end
            hcb_pkg::ST_WSTART:
            begin
                pa_raddr  = NODE_AW'(s_reg) + 1'b1;
                pos_next  = NODE_AW'(s_reg) + 1'b1;
                code_next = '0;
                len_next  = '0;
            end
            hcb_pkg::ST_WP:
            begin
                // pa_rdata is the parent of pos
                par_next      = pa_rdata;
                sym_out_next  = hcb_pkg::SYMBOL_W'(s_reg);
                code_out_next = code_reg;
                len_out_next  = len_reg;
                last_out_next = (NODE_AW'(s_reg) + 1'b1 == n_eff);
            end
            hcb_pkg::ST_WL:
            begin
                code_next = code_reg | (hcb_pkg::CODE_W'(walk_bit) << len_reg);
                len_next  = len_reg + 1'b1;
                pos_next  = par_reg;
                pa_raddr  = par_reg;
            end
            hcb_pkg::ST_EMIT:
            begin
                if (!out_stall && !last_out_reg)
                    s_next = s_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hcb_pkg::ST_LOAD;
            loaded_reg     <= '0;
            chk_valid_reg  <= 1'b0;
            issue_done_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            loaded_reg     <= loaded_next;
            chk_valid_reg  <= chk_valid_next;
            issue_done_reg <= issue_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        chk_k_reg    <= chk_k_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        wa_reg       <= wa_next;
        wb_reg       <= wb_next;
        s_reg        <= s_next;
        pos_reg      <= pos_next;
        par_reg      <= par_next;
        code_reg     <= code_next;
        len_reg      <= len_next;
        sym_out_reg  <= sym_out_next;
        code_out_reg <= code_out_next;
        len_out_reg  <= len_out_next;
        last_out_reg <= last_out_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/hcb_checker.sv -----
`default_nettype none
`include "huffman_code_builder_macros.svh"

module hcb_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            in_valid,
    input wire                            in_stall,
    input wire                            out_valid,
    input wire                            out_stall,
    input wire [hcb_pkg::SYMBOL_W-1:0]    symbol,
    input wire [hcb_pkg::CODE_W-1:0]      code_bits,
    input wire [hcb_pkg::LENGTH_W-1:0]    code_length,
    input wire                            last_code
);

    // no weight is taken while codes are pending
    `HCB_ASSERT_NOW(a_stall_while_out, out_valid, in_stall)
    // a taken weight is never followed at once by a code beat
    `HCB_ASSERT_NEXT(a_no_out_after_in, in_valid && !in_stall, !out_valid)
    // more codes follow a non-final beat, so input stays closed
    `HCB_ASSERT_NEXT(a_hold_until_last, out_valid && !out_stall && !last_code, in_stall)
    // bits above the code length are zero
    `HCB_ASSERT_NOW(a_code_clean, out_valid, (code_bits >> code_length) == '0)
    // stalled beat holds
    `HCB_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(symbol) && $stable(code_bits) && $stable(last_code))

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .last_code   (last_code)
);

`default_nettype wire
